// File: hw/rtl/ptd_pkg.sv
// Package with the types, codes and constants of the periodic priority task dispatcher.
`default_nettype none
package ptd_pkg;

    localparam int TASK_SLOTS_DEF      = 8;
    localparam int PRIORITY_LEVELS_DEF = 4;
    localparam logic [15:0] TICK_WRAP  = 16'd65000;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_CREATE = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_NULL_ID = 2'd2,
        STATUS_SPARE   = 2'd3
    } status_code_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_ACTIVE  = 2'd1,
        SLOT_DELETED = 2'd2,
        SLOT_SPARE   = 2'd3
    } slot_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CREATE,
        ST_DEL_RD,
        ST_DEL_CMP,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_DIV,
        ST_DISP_SEL,
        ST_DISP_RD,
        ST_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  task_id;
        logic [1:0]  priority_req;
        logic [15:0] period;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic       dispatch_valid;
        logic [7:0] dispatch_task;
    } rsp_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/ptd_cmd_if.sv
// Valid/ready channel interfaces for command and response words.
`default_nettype none
interface ptd_cmd_if
    import ptd_pkg::*;
    ();
    logic      valid;
    logic      ready;
    cmd_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ptd_rsp_if
    import ptd_pkg::*;
    ();
    logic      valid;
    logic      ready;
    rsp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/periodic_priority_task_dispatcher.sv
// Create fills one slot; delete searches the used slots in turn; tick walks the used slots
// and runs a bit-serial remainder, one bit a cycle, for each active slot with a nonzero period.
// One word is in work at a time; the next is taken once the result is registered.
// Throughput is set by the slot walk and the shared remainder unit.
// Reset clears the tick count to 1, all slot states, queue heads and fill counts at once;
// slot and queue memories are not cleared and need no clearing pass.
`default_nettype none
module periodic_priority_task_dispatcher
    import ptd_pkg::*;
#(
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
)
(
    input wire logic  clk,
    input wire logic  rst_n,
    ptd_cmd_if.sink   cmd,
    ptd_rsp_if.source rsp
);

    localparam int SW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int FW  = $clog2(TASK_SLOTS + 1);
    localparam int PW  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int QD  = PRIORITY_LEVELS * TASK_SLOTS;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

    fsm_state_t state_reg, state_next;

    logic [7:0]  id_reg;
    logic [PW-1:0] prio_reg;
    logic [15:0] per_reg;

    logic [15:0] tick_reg, tick_next;
    logic [FW-1:0] used_reg, used_next;
    slot_state_t slot_st_reg [TASK_SLOTS];
    slot_state_t slot_st_next [TASK_SLOTS];
    logic [SW-1:0] head_reg [PRIORITY_LEVELS];
    logic [SW-1:0] head_next [PRIORITY_LEVELS];
    logic [FW-1:0] fill_reg [PRIORITY_LEVELS];
    logic [FW-1:0] fill_next [PRIORITY_LEVELS];

    logic [FW-1:0] idx_reg, idx_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [1:0]  status_reg, status_next;
    logic        dvalid_reg, dvalid_next;

    logic        out_valid_reg, out_valid_next;
    rsp_word_t   out_data_reg, out_data_next;

    logic [7:0]    slot_task_mem [TASK_SLOTS];
    logic [PW-1:0] slot_prio_mem [TASK_SLOTS];
    logic [15:0]   slot_per_mem  [TASK_SLOTS];
    logic [7:0]    rd_task_q;
    logic [PW-1:0] rd_prio_q;
    logic [15:0]   rd_per_q;
    logic          slot_we;
    logic [SW-1:0] slot_waddr;

    logic [7:0]     ready_mem [QD];
    logic [7:0]     rq_q;
    logic [QAW-1:0] raddr_reg, raddr_next;
    logic           q_we;
    logic [QAW-1:0] q_waddr;

    logic [PW-1:0] prio_sat;
    logic [16:0]   rem_ext;
    logic [16:0]   rem_sub;
    logic [15:0]   rem_step;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        if (32'(cmd.data.priority_req) >= PRIORITY_LEVELS)
        begin
            prio_sat = PW'(PRIORITY_LEVELS - 1);
        end
        else
        begin
            prio_sat = PW'(cmd.data.priority_req);
        end
    end

    assign rem_ext  = {rem_reg, tick_reg[4'd15 - cnt_reg]};
    assign rem_sub  = rem_ext - {1'b0, rd_per_q};
    assign rem_step = rem_sub[16] ? rem_ext[15:0] : rem_sub[15:0];

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_task_mem[slot_waddr] <= id_reg;
            slot_prio_mem[slot_waddr] <= prio_reg;
            slot_per_mem[slot_waddr]  <= per_reg;
        end
        rd_task_q <= slot_task_mem[idx_reg[SW-1:0]];
        rd_prio_q <= slot_prio_mem[idx_reg[SW-1:0]];
        rd_per_q  <= slot_per_mem[idx_reg[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            ready_mem[q_waddr] <= rd_task_q;
        end
        rq_q <= ready_mem[raddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            id_reg   <= cmd.data.task_id;
            prio_reg <= prio_sat;
            per_reg  <= cmd.data.period;
        end
        out_data_reg <= out_data_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        raddr_reg    <= raddr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_reg      <= 16'd1;
            used_reg      <= '0;
            idx_reg       <= '0;
            status_reg    <= STATUS_OK;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                slot_st_reg[i] <= SLOT_EMPTY;
            end
            for (int p = 0; p < PRIORITY_LEVELS; p++)
            begin
                head_reg[p] <= '0;
                fill_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            status_reg    <= status_next;
            dvalid_reg    <= dvalid_next;
            out_valid_reg <= out_valid_next;
            slot_st_reg   <= slot_st_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
        end
    end

    always_comb
    begin
        logic found;
        int   pos;
        state_next     = state_reg;
        tick_next      = tick_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        dvalid_next    = dvalid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        slot_st_next   = slot_st_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        raddr_next     = raddr_reg;
        slot_we        = 1'b0;
        slot_waddr     = '0;
        q_we           = 1'b0;
        q_waddr        = '0;
        found          = 1'b0;
        pos            = 0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next    = '0;
                status_next = STATUS_OK;
                dvalid_next = 1'b0;
                if (cmd.valid)
                begin
                    unique case (cmd.data.kind)
                        KIND_TICK:   state_next = ST_TICK_RD;
                        KIND_CREATE: state_next = ST_CREATE;
                        KIND_DELETE:
                        begin
                            if (cmd.data.task_id == 8'd0)
                            begin
                                status_next = STATUS_NULL_ID;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_DEL_RD;
                            end
                        end
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_CREATE:
            begin
                if (32'(used_reg) < TASK_SLOTS)
                begin
                    slot_we                     = 1'b1;
                    slot_waddr                  = used_reg[SW-1:0];
                    slot_st_next[used_reg[SW-1:0]] = SLOT_ACTIVE;
                    used_next                   = used_reg + 1'b1;
                end
                else
                begin
                    status_next = STATUS_FULL;
                    for (int i = 0; i < TASK_SLOTS; i++)
                    begin
                        if (!found && slot_st_reg[i] == SLOT_DELETED)
                        begin
                            found           = 1'b1;
                            slot_we         = 1'b1;
                            slot_waddr      = SW'(i);
                            slot_st_next[i] = SLOT_ACTIVE;
                            status_next     = STATUS_OK;
                        end
                    end
                end
                state_next = ST_FINISH;
            end
            ST_DEL_RD:
            begin
                state_next = (idx_reg >= used_reg) ? ST_FINISH : ST_DEL_CMP;
            end
            ST_DEL_CMP:
            begin
                if (rd_task_q == id_reg)
                begin
                    slot_st_next[idx_reg[SW-1:0]] = SLOT_DELETED;
                    state_next                    = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DEL_RD;
                end
            end
            ST_TICK_RD:
            begin
                state_next = (idx_reg >= used_reg) ? ST_DISP_SEL : ST_TICK_CHK;
            end
            ST_TICK_CHK:
            begin
                if (slot_st_reg[idx_reg[SW-1:0]] == SLOT_ACTIVE && rd_per_q != 16'd0)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_TICK_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TICK_RD;
                end
            end
            ST_TICK_DIV:
            begin
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    if (rem_step == 16'd0 && 32'(fill_reg[rd_prio_q]) < TASK_SLOTS)
                    begin
                        pos = int'(head_reg[rd_prio_q]) + int'(fill_reg[rd_prio_q]);
                        if (pos >= TASK_SLOTS)
                        begin
                            pos = pos - TASK_SLOTS;
                        end
                        q_we                 = 1'b1;
                        q_waddr              = QAW'(int'(rd_prio_q) * TASK_SLOTS + pos);
                        fill_next[rd_prio_q] = fill_reg[rd_prio_q] + 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TICK_RD;
                end
            end
            ST_DISP_SEL:
            begin
                for (int p = 0; p < PRIORITY_LEVELS; p++)
                begin
                    if (!found && fill_reg[p] != '0)
                    begin
                        found        = 1'b1;
                        raddr_next   = QAW'(p * TASK_SLOTS + int'(head_reg[p]));
                        fill_next[p] = fill_reg[p] - 1'b1;
                        if (32'(head_reg[p]) == TASK_SLOTS - 1)
                        begin
                            head_next[p] = '0;
                        end
                        else
                        begin
                            head_next[p] = head_reg[p] + 1'b1;
                        end
                    end
                end
                dvalid_next = found;
                tick_next   = (tick_reg + 16'd1 == TICK_WRAP) ? 16'd1 : tick_reg + 16'd1;
                state_next  = ST_DISP_RD;
            end
            ST_DISP_RD:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = status_reg;
                    out_data_next.dispatch_valid = dvalid_reg;
                    out_data_next.dispatch_task  = dvalid_reg ? rq_q : 8'd0;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg != 16'd0 && tick_reg < TICK_WRAP)
        else $error("tick count out of range");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= TASK_SLOTS)
        else $error("slot use count exceeds table size");

    a_idle_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.dispatch_valid |-> out_data_reg.dispatch_task == 8'd0)
        else $error("task id reported without a dispatch");

    a_tick_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.dispatch_valid |-> out_data_reg.status == STATUS_OK)
        else $error("dispatch reported with nonzero status");
`endif

endmodule
`default_nettype wire
